### rtl/nlcc_pkg.sv
// Package for the NMEA line checksum checker: byte codes, verdict codes,
// line state and result types, and the hex digit decoder.
// No dependencies.
package nlcc_pkg;

   localparam int unsigned LEN_W = 7;
   localparam int unsigned DEFAULT_MAX_LINE = 90;

   localparam logic [7:0] CHAR_NUL    = 8'h00;
   localparam logic [7:0] CHAR_NL     = 8'h0A;
   localparam logic [7:0] CHAR_DOLLAR = 8'h24;
   localparam logic [7:0] CHAR_STAR   = 8'h2A;

   localparam logic [1:0] VERDICT_ACCEPTED  = 2'd0;
   localparam logic [1:0] VERDICT_BAD_START = 2'd1;
   localparam logic [1:0] VERDICT_NO_SUM    = 2'd2;
   localparam logic [1:0] VERDICT_MISMATCH  = 2'd3;

   typedef struct packed {
      logic [LEN_W-1:0] byte_count;
      logic             start_good;
      logic [7:0]       xor_sum;
      logic             star_seen;
      logic [7:0]       hex_value;
      logic             hex_digit_seen;
      logic             hex_closed;
      logic             hex_too_big;
      logic             text_ended;
   } line_state_type;

   typedef struct packed {
      logic [1:0]       verdict;
      logic [7:0]       computed_sum;
      logic [LEN_W-1:0] line_length;
   } result_type;

   typedef struct packed {
      logic       valid;
      logic [3:0] value;
   } hex_digit_type;

   function automatic hex_digit_type hex_digit_of(input logic [7:0] b);
      hex_digit_type d;
      d.valid = 1'b1;
      d.value = 4'd0;
      if (b >= 8'h30 && b <= 8'h39) begin
         d.value = 4'(b - 8'h30);
      end else if (b >= 8'h61 && b <= 8'h66) begin
         d.value = 4'(b - 8'h57);
      end else if (b >= 8'h41 && b <= 8'h46) begin
         d.value = 4'(b - 8'h37);
      end else begin
         d.valid = 1'b0;
      end
      return d;
   endfunction

endpackage

### rtl/nlcc_line_track.sv
// Line framing and checksum state: updates the per-line state with one byte
// and produces the verdict at each newline. Depends on nlcc_pkg.
module nlcc_line_track
   import nlcc_pkg::*;
#(
   parameter int unsigned MAX_LINE = DEFAULT_MAX_LINE
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       byte_fire,
   input  logic [7:0] byte_data,
   output logic       result_valid,
   output result_type result
);

   line_state_type   state_ff;
   line_state_type   state_in;
   line_state_type   upd;
   logic [LEN_W-1:0] pos;
   logic [LEN_W:0]   len;
   logic             overlong;
   hex_digit_type    digit;

   assign pos      = state_ff.byte_count;
   assign len      = {1'b0, pos} + {{LEN_W{1'b0}}, 1'b1};
   assign overlong = len > (LEN_W+1)'(MAX_LINE);
   assign digit    = hex_digit_of(byte_data);

   // Examine the byte; a zero byte freezes everything but the framing.
   always_comb begin
      upd = state_ff;
      if (!state_ff.text_ended) begin
         if (byte_data == CHAR_NUL) begin
            upd.text_ended = 1'b1;
            upd.hex_closed = 1'b1;
         end else if (pos == '0) begin
            upd.start_good = (byte_data == CHAR_DOLLAR);
         end else begin
            if (pos == LEN_W'(1) && byte_data == CHAR_DOLLAR) begin
               upd.start_good = 1'b0;
            end
            if (!state_ff.star_seen) begin
               if (byte_data == CHAR_STAR) begin
                  upd.star_seen = 1'b1;
               end else begin
                  upd.xor_sum = state_ff.xor_sum ^ byte_data;
               end
            end else if (!state_ff.hex_closed) begin
               if (!digit.valid) begin
                  upd.hex_closed = 1'b1;
               end else begin
                  upd.hex_digit_seen = 1'b1;
                  if (!state_ff.hex_too_big) begin
                     // Shifting in another digit overflows once the high nibble is set.
                     if (state_ff.hex_value[7:4] != 4'd0) begin
                        upd.hex_too_big = 1'b1;
                     end else begin
                        upd.hex_value = {state_ff.hex_value[3:0], digit.value};
                     end
                  end
               end
            end
         end
      end
      upd.byte_count = len[LEN_W-1:0];
   end

   always_comb begin
      result_valid        = !overlong && byte_data == CHAR_NL;
      result.computed_sum = upd.xor_sum;
      result.line_length  = len[LEN_W-1:0];
      if (!upd.start_good) begin
         result.verdict = VERDICT_BAD_START;
      end else if (!upd.star_seen || !upd.hex_digit_seen) begin
         result.verdict = VERDICT_NO_SUM;
      end else if (upd.hex_too_big || upd.hex_value != upd.xor_sum) begin
         result.verdict = VERDICT_MISMATCH;
      end else begin
         result.verdict = VERDICT_ACCEPTED;
      end
   end

   always_comb begin
      state_in = state_ff;
      if (byte_fire) begin
         if (overlong || byte_data == CHAR_NL) begin
            state_in = '0;
         end else begin
            state_in = upd;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### rtl/nmea_line_checksum_checker.sv
// Top level of the NMEA line checksum checker: input byte register, line
// tracker and result register. Depends on nlcc_pkg and nlcc_line_track.
//
// Usage: received bytes enter on the req_ channel (req_valid, req_ready,
// req_rx_byte), one item per byte. Each newline that closes a line of at
// most MAX_LINE bytes yields one item on the rsp_ channel with the verdict,
// the XOR checksum computed over the line, and the line length including
// the newline. A line whose byte MAX_LINE+1 arrives before its newline is
// dropped with no result, and that byte starts nothing.
// Throughput is one byte per cycle, except while a newline's result waits
// behind a result that the receiver has not yet taken. A byte is held in
// the input register, and a newline's result is then stored in the result register.
// The whole checksum update is one pass of flag and XOR logic between
// those two registers.
// Reset empties both registers and clears the line state; the first byte after
// reset opens a new line. When the receiver holds rsp_ready low with a
// result pending, the line tracker stops only when the byte in the input
// register would make another result, and req_ready falls while it waits.
module nmea_line_checksum_checker
   import nlcc_pkg::*;
#(
   parameter int unsigned MAX_LINE = DEFAULT_MAX_LINE
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [7:0]       req_rx_byte,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [1:0]       rsp_verdict,
   output logic [7:0]       rsp_computed_sum,
   output logic [LEN_W-1:0] rsp_line_length
);

   logic       byte_valid_ff;
   logic       byte_valid_in;
   logic [7:0] byte_ff;
   logic [7:0] byte_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   result_type rsp_ff;
   result_type rsp_in;
   logic       out_free;
   logic       proc_fire;
   logic       track_valid;
   result_type track_result;

   // The tracker only stalls when it could not store a result it makes.
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign proc_fire = byte_valid_ff && (out_free || !track_valid);
   assign req_ready = !byte_valid_ff || proc_fire;

   nlcc_line_track #(
      .MAX_LINE(MAX_LINE)
   ) u_line_track (
      .clock       (clock),
      .reset       (reset),
      .byte_fire   (proc_fire),
      .byte_data   (byte_ff),
      .result_valid(track_valid),
      .result      (track_result)
   );

   always_comb begin
      byte_valid_in = byte_valid_ff;
      byte_in       = byte_ff;
      if (req_valid && req_ready) begin
         byte_valid_in = 1'b1;
         byte_in       = req_rx_byte;
      end else if (proc_fire) begin
         byte_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (proc_fire && track_valid) begin
         rsp_valid_in = 1'b1;
         rsp_in       = track_result;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         byte_valid_ff <= byte_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      byte_ff <= byte_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_verdict      = rsp_ff.verdict;
   assign rsp_computed_sum = rsp_ff.computed_sum;
   assign rsp_line_length  = rsp_ff.line_length;

   // A result produced by the tracker always lands in the result register.
   assert property (@(posedge clock) disable iff (reset)
      proc_fire && track_valid |=> rsp_valid_ff)
      else $error("result from line tracker was lost");

   // A pending result that was not taken is never overwritten.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |-> !(proc_fire && track_valid))
      else $error("pending result overwritten");

   // Delivered line lengths stay within the framing limit.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_ff.line_length != '0
                       && rsp_ff.line_length <= LEN_W'(MAX_LINE))
      else $error("line length out of range");

   // Reset empties both registers.
   assert property (@(posedge clock)
      reset |=> !rsp_valid_ff && !byte_valid_ff)
      else $error("registers not empty after reset");

endmodule
